### sv/ctp_pkg.sv
`timescale 1ns / 1ps
// ctp_pkg: shared types, constants and helper functions of the Cartesian-to-polar converter.
// No dependencies; imported by every module of the block.

package ctp_pkg;

  // Default geometry of the block
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_FRAC_DEF  = 7;

  // Fixed result field widths
  localparam int MAG_WIDTH   = 16;
  localparam int ANGLE_WIDTH = 16;

  // CORDIC vectoring core
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_TOP   = 41;  // |x|, |y| are aligned so their MSB lands in the bit just below this
  localparam int CORDIC_WIDTH = 44;  // covers the CORDIC gain plus sign
  localparam int Z_FRAC       = 20;  // angle accumulator in 2^-20 degree
  localparam int Z_WIDTH      = 28;
  localparam int ATAN_WIDTH   = 27;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;  // iterations plus clamp/round

  // Root pipeline: square, sum, one stage per root bit, round
  localparam int SQRT_EXTRA = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // atan(2^-i) in degrees, scaled by 2^20, rounded to nearest
  localparam logic [ATAN_WIDTH-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  // 90 degrees in accumulator units
  localparam logic [ATAN_WIDTH-1:0] Z_MAX = 27'd94371840;

  // Location code of a point
  typedef enum logic [2:0] {
    LOC_ORIGIN = 3'd0,
    LOC_QUAD1  = 3'd1,
    LOC_QUAD2  = 3'd2,
    LOC_QUAD3  = 3'd3,
    LOC_QUAD4  = 3'd4,
    LOC_X_AXIS = 3'd5,
    LOC_Y_AXIS = 3'd6
  } ctp_loc_e;

  // Classification that travels alongside the coordinates
  typedef struct packed {
    ctp_loc_e loc;
    logic     neg_x;
    logic     neg_y;
  } ctp_meta_t;

  // First-quadrant angle width in 2^-afb degree units (0..90 degrees)
  function automatic int ctp_phi_width(input int afb);
    return ATAN_WIDTH - Z_FRAC + afb;
  endfunction

  // Latency of the back pipeline: the longer of the angle and root paths
  function automatic int ctp_back_latency(input int coord_width);
    return (coord_width + SQRT_EXTRA > CORDIC_LAT) ? coord_width + SQRT_EXTRA : CORDIC_LAT;
  endfunction

endpackage

### sv/ctp_front.sv
`timescale 1ns / 1ps
// ctp_front: input register of the converter; takes a point, forms |x|, |y| and its location.
// Depends on ctp_pkg.

module ctp_front import ctp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic                          full_i,
  output logic                          push_o,
  output logic        [COORD_WIDTH-1:0] abs_x_o,
  output logic        [COORD_WIDTH-1:0] abs_y_o,
  output ctp_meta_t                     meta_o
);

  logic                   neg_x, neg_y, zero_x, zero_y;
  logic [COORD_WIDTH-1:0] abs_x, abs_y;
  ctp_loc_e               loc;
  logic                   load;
  logic                   valid_q, valid_d;
  logic [COORD_WIDTH-1:0] abs_x_q, abs_y_q;
  ctp_meta_t              meta_q;

  // Sign, magnitude and zero tests
  assign neg_x  = coord_x_i[COORD_WIDTH-1];
  assign neg_y  = coord_y_i[COORD_WIDTH-1];
  assign abs_x  = neg_x ? $unsigned(-coord_x_i) : $unsigned(coord_x_i);
  assign abs_y  = neg_y ? $unsigned(-coord_y_i) : $unsigned(coord_y_i);
  assign zero_x = (coord_x_i == '0);
  assign zero_y = (coord_y_i == '0);

  // Location decode
  always_comb begin
    if (zero_x && zero_y) begin
      loc = LOC_ORIGIN;
    end else if (zero_y) begin
      loc = LOC_X_AXIS;
    end else if (zero_x) begin
      loc = LOC_Y_AXIS;
    end else begin
      unique case ({neg_x, neg_y})
        2'b00: loc = LOC_QUAD1;
        2'b10: loc = LOC_QUAD2;
        2'b11: loc = LOC_QUAD3;
        2'b01: loc = LOC_QUAD4;
      endcase
    end
  end

  // Handshake: hold the register only while the queue is full
  assign in_stall_o = valid_q && full_i;
  assign push_o     = valid_q && !full_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      abs_x_q <= abs_x;
      abs_y_q <= abs_y;
      meta_q  <= '{loc: loc, neg_x: neg_x, neg_y: neg_y};
    end
  end

  assign abs_x_o = abs_x_q;
  assign abs_y_o = abs_y_q;
  assign meta_o  = meta_q;

endmodule

### sv/ctp_queue.sv
`timescale 1ns / 1ps
// ctp_queue: short FIFO that decouples the front register from the back pipeline.
// Depends on ctp_pkg for its depth.

module ctp_queue import ctp_pkg::*; #(
  parameter int DATA_WIDTH = $bits(ctp_meta_t) + 2 * COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output logic [DATA_WIDTH-1:0] head_data_o
);

  localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_WIDTH-1:0]  count_q, count_d;

  function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] ptr);
    return (ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Pointer and fill update; the producers never push when full or pop when empty
  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_WIDTH'(push_i) - CNT_WIDTH'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o       = (count_q == CNT_WIDTH'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

endmodule

### sv/ctp_cordic.sv
`timescale 1ns / 1ps
// ctp_cordic: pipelined CORDIC vectoring core giving the first-quadrant angle of (|x|, |y|).
// One iteration per stage, then clamp and round; depends on ctp_pkg.

module ctp_cordic import ctp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
  parameter int LATENCY         = CORDIC_LAT
) (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic [COORD_WIDTH-1:0]                      abs_x_i,
  input  logic [COORD_WIDTH-1:0]                      abs_y_i,
  output logic [ctp_phi_width(ANGLE_FRAC_BITS)-1:0]   phi_o
);

  localparam int PRE_SHIFT = CORDIC_TOP - COORD_WIDTH;
  localparam int RND_SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
  localparam int PHI_WIDTH = ctp_phi_width(ANGLE_FRAC_BITS);
  localparam int PAD       = LATENCY - CORDIC_LAT;
  localparam logic [ATAN_WIDTH-1:0] RND_HALF = ATAN_WIDTH'(1 << (RND_SHIFT - 1));

  logic signed [CORDIC_WIDTH-1:0] x_init, y_init;
  logic signed [CORDIC_WIDTH-1:0] x_q [CORDIC_STEPS];
  logic signed [CORDIC_WIDTH-1:0] y_q [CORDIC_STEPS];
  logic signed [CORDIC_WIDTH-1:0] x_d [CORDIC_STEPS];
  logic signed [CORDIC_WIDTH-1:0] y_d [CORDIC_STEPS];
  logic signed [Z_WIDTH-1:0]      z_q [CORDIC_STEPS];
  logic signed [Z_WIDTH-1:0]      z_d [CORDIC_STEPS];
  logic signed [Z_WIDTH-1:0]      z_last;
  logic [ATAN_WIDTH-1:0]          z_clamp, z_round;
  logic [PHI_WIDTH-1:0]           phi_q;

  // Align the operands to the top of the datapath
  assign x_init = $signed({{(CORDIC_WIDTH - COORD_WIDTH){1'b0}}, abs_x_i} << PRE_SHIFT);
  assign y_init = $signed({{(CORDIC_WIDTH - COORD_WIDTH){1'b0}}, abs_y_i} << PRE_SHIFT);

  // One micro-rotation per stage, driving y toward zero
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_WIDTH-1:0] x_in, y_in;
    logic signed [Z_WIDTH-1:0]      z_in, rot;
    if (i == 0) begin : g_first
      assign x_in = x_init;
      assign y_in = y_init;
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end
    assign rot    = $signed({1'b0, ATAN_TAB[i]});
    assign x_d[i] = y_in[CORDIC_WIDTH-1] ? x_in - (y_in >>> i) : x_in + (y_in >>> i);
    assign y_d[i] = y_in[CORDIC_WIDTH-1] ? y_in + (x_in >>> i) : y_in - (x_in >>> i);
    assign z_d[i] = y_in[CORDIC_WIDTH-1] ? z_in - rot : z_in + rot;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // Clamp to 0..90 degrees and round half up to the output resolution
  assign z_last = z_q[CORDIC_STEPS-1];

  always_comb begin
    if (z_last[Z_WIDTH-1]) begin
      z_clamp = '0;
    end else if (z_last[ATAN_WIDTH-1:0] > Z_MAX) begin
      z_clamp = Z_MAX;
    end else begin
      z_clamp = z_last[ATAN_WIDTH-1:0];
    end
    z_round = z_clamp + RND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q <= z_round[ATAN_WIDTH-1:RND_SHIFT];
    end
  end

  // Balance against the root path
  if (PAD > 0) begin : g_pad
    logic [PHI_WIDTH-1:0] pad_q [PAD];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[0] <= phi_q;
        for (int k = 1; k < PAD; k++) begin
          pad_q[k] <= pad_q[k-1];
        end
      end
    end
    assign phi_o = pad_q[PAD-1];
  end else begin : g_no_pad
    assign phi_o = phi_q;
  end

endmodule

### sv/ctp_sqrt.sv
`timescale 1ns / 1ps
// ctp_sqrt: pipelined magnitude unit, rounded square root of x^2 + y^2.
// Squares, sum, one root bit per stage, round; depends on ctp_pkg.

module ctp_sqrt import ctp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int LATENCY     = COORD_WIDTH_DEF + SQRT_EXTRA
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [COORD_WIDTH-1:0] abs_x_i,
  input  logic [COORD_WIDTH-1:0] abs_y_i,
  output logic [COORD_WIDTH-1:0] mag_o
);

  localparam int RAD_WIDTH = 2 * COORD_WIDTH;
  localparam int REM_WIDTH = COORD_WIDTH + 1;
  localparam int PAD       = LATENCY - (COORD_WIDTH + SQRT_EXTRA);

  logic [RAD_WIDTH-1:0]   sq_x_q, sq_y_q, sum_q;
  logic [COORD_WIDTH-1:0] root_q [COORD_WIDTH];
  logic [COORD_WIDTH-1:0] root_d [COORD_WIDTH];
  logic [REM_WIDTH-1:0]   rem_q  [COORD_WIDTH];
  logic [REM_WIDTH-1:0]   rem_d  [COORD_WIDTH];
  logic [RAD_WIDTH-1:0]   rad_q  [COORD_WIDTH];
  logic [RAD_WIDTH-1:0]   rad_d  [COORD_WIDTH];
  logic [COORD_WIDTH-1:0] root_last, mag_q;
  logic [REM_WIDTH-1:0]   rem_last;

  // Squares, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q <= RAD_WIDTH'(abs_x_i * abs_x_i);
      sq_y_q <= RAD_WIDTH'(abs_y_i * abs_y_i);
      sum_q  <= sq_x_q + sq_y_q;
    end
  end

  // Restoring square root, two radicand bits per stage
  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_digit
    localparam int BIT_HI = RAD_WIDTH - 1 - 2 * k;
    logic [COORD_WIDTH-1:0] root_in;
    logic [REM_WIDTH-1:0]   rem_in;
    logic [RAD_WIDTH-1:0]   rad_in;
    logic [REM_WIDTH+1:0]   rem_ext, trial;
    logic                   fits;
    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = sum_q;
    end else begin : g_next
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
    end
    assign rem_ext  = {rem_in, rad_in[BIT_HI -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign fits     = (rem_ext >= trial);
    assign root_d[k] = {root_in[COORD_WIDTH-2:0], fits};
    assign rem_d[k]  = fits ? REM_WIDTH'(rem_ext - trial) : rem_ext[REM_WIDTH-1:0];
    assign rad_d[k]  = rad_in;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
      rem_q  <= rem_d;
      rad_q  <= rad_d;
    end
  end

  // Round half up: the remainder beyond the root means sqrt >= root + 1/2
  assign root_last = root_q[COORD_WIDTH-1];
  assign rem_last  = rem_q[COORD_WIDTH-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= root_last + COORD_WIDTH'(rem_last > {1'b0, root_last});
    end
  end

  // Balance against the angle path
  if (PAD > 0) begin : g_pad
    logic [COORD_WIDTH-1:0] pad_q [PAD];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[0] <= mag_q;
        for (int k = 1; k < PAD; k++) begin
          pad_q[k] <= pad_q[k-1];
        end
      end
    end
    assign mag_o = pad_q[PAD-1];
  end else begin : g_no_pad
    assign mag_o = mag_q;
  end

endmodule

### sv/ctp_back.sv
`timescale 1ns / 1ps
// ctp_back: back pipeline; runs the angle and root units in lockstep, folds the angle
// into the full circle and holds the output register. Depends on ctp_pkg, ctp_cordic, ctp_sqrt.

module ctp_back import ctp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  logic [COORD_WIDTH-1:0] head_abs_x_i,
  input  logic [COORD_WIDTH-1:0] head_abs_y_i,
  input  ctp_meta_t              head_meta_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [MAG_WIDTH-1:0]   magnitude_o,
  output logic [ANGLE_WIDTH-1:0] angle_deg_o,
  output logic [2:0]             location_o
);

  localparam int PIPE_LAT  = ctp_back_latency(COORD_WIDTH);
  localparam int PHI_WIDTH = ctp_phi_width(ANGLE_FRAC_BITS);
  localparam int ANG_WIDTH = PHI_WIDTH + 2;  // 0..360 degrees
  localparam logic [ANG_WIDTH-1:0] ANG_90  = ANG_WIDTH'(90  * (1 << ANGLE_FRAC_BITS));
  localparam logic [ANG_WIDTH-1:0] ANG_180 = ANG_WIDTH'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic [ANG_WIDTH-1:0] ANG_270 = ANG_WIDTH'(270 * (1 << ANGLE_FRAC_BITS));
  localparam logic [ANG_WIDTH-1:0] ANG_360 = ANG_WIDTH'(360 * (1 << ANGLE_FRAC_BITS));

  logic                   en;
  logic [PIPE_LAT-1:0]    valid_q;
  ctp_meta_t              meta_q [PIPE_LAT];
  ctp_meta_t              meta_last;
  logic [PHI_WIDTH-1:0]   phi;
  logic [ANG_WIDTH-1:0]   phi_ext, ang_d;
  logic [COORD_WIDTH-1:0] mag;
  logic                   out_valid_q;
  logic [MAG_WIDTH-1:0]   mag_q;
  logic [ANGLE_WIDTH-1:0] ang_q;
  ctp_loc_e               loc_q;

  // Whole pipeline advances unless a result sits stalled in the output register
  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && head_valid_i;

  ctp_cordic #(
    .COORD_WIDTH    (COORD_WIDTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .LATENCY        (PIPE_LAT)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .abs_x_i(head_abs_x_i),
    .abs_y_i(head_abs_y_i),
    .phi_o  (phi)
  );

  ctp_sqrt #(
    .COORD_WIDTH(COORD_WIDTH),
    .LATENCY    (PIPE_LAT)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .abs_x_i(head_abs_x_i),
    .abs_y_i(head_abs_y_i),
    .mag_o  (mag)
  );

  // Valid and classification ride alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_LAT-2:0], head_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= head_meta_i;
      for (int k = 1; k < PIPE_LAT; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  assign meta_last = meta_q[PIPE_LAT-1];
  assign phi_ext   = ANG_WIDTH'(phi);

  // Fold the first-quadrant angle into the full circle
  always_comb begin
    unique case (meta_last.loc)
      LOC_QUAD1:  ang_d = phi_ext;
      LOC_QUAD2:  ang_d = ANG_180 - phi_ext;
      LOC_QUAD3:  ang_d = ANG_180 + phi_ext;
      LOC_QUAD4:  ang_d = (phi_ext == '0) ? '0 : ANG_360 - phi_ext;
      LOC_X_AXIS: ang_d = meta_last.neg_x ? ANG_180 : '0;
      LOC_Y_AXIS: ang_d = meta_last.neg_y ? ANG_270 : ANG_90;
      default:    ang_d = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= MAG_WIDTH'(mag);
      ang_q <= ANGLE_WIDTH'(ang_d);
      loc_q <= meta_last.loc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign angle_deg_o = ang_q;
  assign location_o  = loc_q;

endmodule

### sv/cartesian_to_polar.sv
`timescale 1ns / 1ps
// Cartesian-to-polar converter, top level (needs ctp_pkg, ctp_front, ctp_queue and ctp_back).
// Each transfer in carries a signed point (x, y); each transfer out carries the rounded
// magnitude sqrt(x^2 + y^2), the angle over the full circle in 2^-ANGLE_FRAC_BITS degree
// and a location code (origin, quadrant I to IV, x axis, y axis); axis points give 0, 90,
// 180 or 270 degrees and the origin gives zero for both. The block takes one point per
// clock cycle and returns one result per cycle while the output is not stalled. A point
// passes through the input register, the two-entry queue, then the longer of the 24-stage
// CORDIC vectoring pipeline plus its rounding stage and the square/sum/one-bit-per-stage
// root pipeline, then the output register. A stall on the output freezes the back
// pipeline; in_stall_o rises once both queue entries and the input register hold a point,
// so up to three points wait in front of the frozen pipeline.

module cartesian_to_polar import ctp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [MAG_WIDTH-1:0]   magnitude_o,
  output logic        [ANGLE_WIDTH-1:0] angle_deg_o,
  output logic        [2:0]             location_o
);

  localparam int QUEUE_WIDTH = $bits(ctp_meta_t) + 2 * COORD_WIDTH;

  logic                   push, full, pop, head_valid;
  logic [COORD_WIDTH-1:0] front_abs_x, front_abs_y, head_abs_x, head_abs_y;
  ctp_meta_t              front_meta, head_meta;
  logic [QUEUE_WIDTH-1:0] push_data, head_data;

  ctp_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .full_i    (full),
    .push_o    (push),
    .abs_x_o   (front_abs_x),
    .abs_y_o   (front_abs_y),
    .meta_o    (front_meta)
  );

  assign push_data = {front_meta, front_abs_x, front_abs_y};

  ctp_queue #(
    .DATA_WIDTH(QUEUE_WIDTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_data_o (head_data)
  );

  assign {head_meta, head_abs_x, head_abs_y} = head_data;

  ctp_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_abs_x_i(head_abs_x),
    .head_abs_y_i(head_abs_y),
    .head_meta_i (head_meta),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .magnitude_o (magnitude_o),
    .angle_deg_o (angle_deg_o),
    .location_o  (location_o)
  );

endmodule

### sv/ctp_checker.sv
`timescale 1ns / 1ps
// ctp_checker: port-level assertions for cartesian_to_polar, attached by the bind below.
// Depends on ctp_pkg and the top level's ports.

module ctp_checker import ctp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [MAG_WIDTH-1:0]   magnitude_o,
  input logic [ANGLE_WIDTH-1:0] angle_deg_o,
  input logic [2:0]             location_o
);

  localparam logic [ANGLE_WIDTH-1:0] ANG_180 = ANGLE_WIDTH'(180 * (1 << ANGLE_FRAC_BITS));

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(magnitude_o)
      && $stable(angle_deg_o) && $stable(location_o))
    else $error("stalled result changed");

  // The origin reports zero magnitude and zero angle
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && location_o == LOC_ORIGIN |-> magnitude_o == '0 && angle_deg_o == '0)
    else $error("origin result not zero");

  // A point on the x axis lies at 0 or 180 degrees
  a_x_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && location_o == LOC_X_AXIS |-> angle_deg_o == '0 || angle_deg_o == ANG_180)
    else $error("x axis angle off axis");

  // A free output leaves room in the queue, so input is taken again in the next cycle
  a_input_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |=> !in_stall_o)
    else $error("input stalled although output was free");

endmodule

bind cartesian_to_polar ctp_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_ctp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .magnitude_o(magnitude_o),
  .angle_deg_o(angle_deg_o),
  .location_o (location_o)
);
